// ----- design/twcs_pkg.sv -----
// twcs_pkg: shared types, codes, widths and helpers of the textured wall column span block
// used by every module in the design folder; depends on nothing

package twcs_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 12;
    localparam int SCR_W       = 12;
    localparam int PITCH_W     = 13;
    localparam int TEX_W       = 11;
    localparam int TEXCOL_W    = 10;
    localparam int FIELD_W     = 16;
    localparam int WALL_W      = 15;
    localparam int CENTER_W    = 17;
    localparam int FACE_SIDE_W = 3;
    localparam int POS_W       = 40;
    localparam int STEP_W      = 32;
    localparam int PIXEL_W     = 24;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int TEX_MAX     = 1024;

    localparam int DIVIDEND_W  = TEX_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);
    localparam int PROD_W      = CENTER_W + STEP_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_HEIGHT = 2'd3;

    localparam logic [SCR_W-1:0]   SCREEN_HEIGHT_RST  = 12'd480;
    localparam logic [PITCH_W-1:0] ROW_PITCH_RST      = 13'd640;
    localparam logic [TEX_W-1:0]   TEXTURE_WIDTH_RST  = 11'd64;
    localparam logic [TEX_W-1:0]   TEXTURE_HEIGHT_RST = 11'd64;

    localparam logic [1:0] CMD_ADVANCE = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [ROW_W-1:0]           row_top;
        logic [ROW_W-1:0]           row_bot;
        logic [COL_W-1:0]           column;
        logic [TEXCOL_W-1:0]        texcol;
        logic [FACE_SIDE_W-1:0]     face_side;
        logic [WALL_W-1:0]          wall_h;
        logic signed [CENTER_W-1:0] center_off;
    } item_t;

    typedef struct packed {
        logic [SCR_W-1:0]   screen_height;
        logic [PITCH_W-1:0] row_pitch;
        logic [TEX_W-1:0]   texture_width;
        logic [TEX_W-1:0]   texture_height;
    } cfg_t;

    // zero acts as one, sizes beyond the maximum act as the maximum
    function automatic logic [TEX_W-1:0] tex_size(input logic [TEX_W-1:0] r);
        logic [TEX_W-1:0] s;
        if (r == '0) begin
            s = TEX_W'(1);
        end else if (r > TEX_W'(TEX_MAX)) begin
            s = TEX_W'(TEX_MAX);
        end else begin
            s = r;
        end
        return s;
    endfunction

endpackage

// ----- design/twcs_front.sv -----
// twcs_front: accepts input requests, clamps the span and classifies each one for the queue
// depends on twcs_pkg

module twcs_front (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [twcs_pkg::COL_W-1:0]        s_column_x,
    input  logic signed [twcs_pkg::FIELD_W-1:0] s_span_top,
    input  logic signed [twcs_pkg::FIELD_W-1:0] s_span_bottom,
    input  logic signed [twcs_pkg::FIELD_W-1:0] s_wall_height,
    input  logic signed [twcs_pkg::FIELD_W-1:0] s_texture_column,
    input  logic [1:0]                        s_wall_face,
    input  logic                              s_shaded_side,
    input  twcs_pkg::cfg_t                    cfg,
    input  logic                              q_full,
    output logic                              q_push,
    output twcs_pkg::item_t                   q_item
);

    logic [twcs_pkg::SCR_W-1:0]            scr;
    logic [twcs_pkg::TEX_W-1:0]            tw;
    logic signed [twcs_pkg::FIELD_W:0]     top_c;
    logic signed [twcs_pkg::FIELD_W:0]     bot_c;
    logic signed [twcs_pkg::FIELD_W:0]     scr_s;
    logic signed [twcs_pkg::FIELD_W:0]     tw_s;
    logic signed [twcs_pkg::FIELD_W:0]     tc_s;
    logic [twcs_pkg::TEXCOL_W-1:0]         tc_c;
    logic                                  empty;

    assign scr = (cfg.screen_height == '0) ? twcs_pkg::SCR_W'(1) : cfg.screen_height;
    assign tw  = twcs_pkg::tex_size(cfg.texture_width);

    assign scr_s = $signed({{(twcs_pkg::FIELD_W + 1 - twcs_pkg::SCR_W){1'b0}}, scr});
    assign tw_s  = $signed({{(twcs_pkg::FIELD_W + 1 - twcs_pkg::TEX_W){1'b0}}, tw});
    assign tc_s  = {s_texture_column[twcs_pkg::FIELD_W-1], s_texture_column};

    always_comb begin
        top_c = {s_span_top[twcs_pkg::FIELD_W-1], s_span_top};
        if (s_span_top < 0) begin
            top_c = '0;
        end
        bot_c = {s_span_bottom[twcs_pkg::FIELD_W-1], s_span_bottom};
        if (bot_c >= scr_s) begin
            bot_c = scr_s - 17'sd1;
        end
        empty = (top_c > bot_c);

        if (tc_s < 0) begin
            tc_c = '0;
        end else if (tc_s >= tw_s) begin
            tc_c = twcs_pkg::TEXCOL_W'(tw - twcs_pkg::TEX_W'(1));
        end else begin
            tc_c = tc_s[twcs_pkg::TEXCOL_W-1:0];
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.row_top   = top_c[twcs_pkg::ROW_W-1:0];
        q_item.row_bot   = bot_c[twcs_pkg::ROW_W-1:0];
        q_item.column    = s_column_x;
        q_item.texcol    = tc_c;
        q_item.face_side = {s_shaded_side, s_wall_face};
        q_item.wall_h    = s_wall_height[twcs_pkg::WALL_W-1:0];
        q_item.center_off =
            $signed({{(twcs_pkg::CENTER_W - twcs_pkg::ROW_W){1'b0}},
                     top_c[twcs_pkg::ROW_W-1:0]})
          - $signed({{(twcs_pkg::CENTER_W - twcs_pkg::SCR_W + 1){1'b0}},
                     scr[twcs_pkg::SCR_W-1:1]})
          + $signed({{(twcs_pkg::CENTER_W - twcs_pkg::WALL_W + 1){1'b0}},
                     s_wall_height[twcs_pkg::WALL_W-1:1]});
        if (s_mode) begin
            q_item.kind = twcs_pkg::CMD_ADVANCE;
        end else if (s_wall_height <= 0 || empty) begin
            q_item.kind = twcs_pkg::CMD_CLEAR;
        end else begin
            q_item.kind = twcs_pkg::CMD_LOAD;
        end
    end

endmodule

// ----- design/twcs_queue.sv -----
// twcs_queue: short request queue between the front and the back
// depends on twcs_pkg

module twcs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  twcs_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output twcs_pkg::item_t q_item
);

    twcs_pkg::item_t                entry_reg [twcs_pkg::QUEUE_DEPTH];
    logic [twcs_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [twcs_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [twcs_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full    = (count_reg == twcs_pkg::QCNT_W'(twcs_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == twcs_pkg::QPTR_W'(twcs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + twcs_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == twcs_pkg::QPTR_W'(twcs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + twcs_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + twcs_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - twcs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/twcs_div.sv -----
// twcs_div: bit-serial restoring divider for the texture step, one quotient bit a cycle
// depends on twcs_pkg

module twcs_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [twcs_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [twcs_pkg::WALL_W-1:0]       divisor,
    output logic                              done,
    output logic [twcs_pkg::DIVIDEND_W-1:0]   quotient
);

    logic [twcs_pkg::WALL_W-1:0]       rem_reg, rem_next;
    logic [twcs_pkg::DIVIDEND_W-1:0]   quo_reg, quo_next;
    logic [twcs_pkg::WALL_W-1:0]       dsr_reg;
    logic [twcs_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [twcs_pkg::WALL_W:0]         trial;
    logic [twcs_pkg::WALL_W:0]         diff;
    logic                              ge;

    assign trial = {rem_reg, quo_reg[twcs_pkg::DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = twcs_pkg::DIV_CNT_W'(twcs_pkg::DIVIDEND_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[twcs_pkg::WALL_W-1:0] : trial[twcs_pkg::WALL_W-1:0];
            quo_next = {quo_reg[twcs_pkg::DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg - twcs_pkg::DIV_CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/twcs_back.sv -----
// twcs_back: span state, step and start computation, row stepping and the result register
// depends on twcs_pkg and twcs_div

module twcs_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  twcs_pkg::cfg_t                    cfg,
    input  logic                              q_valid,
    input  twcs_pkg::item_t                   q_item,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [twcs_pkg::PIXEL_W-1:0]      m_pixel_index,
    output logic [twcs_pkg::TEXCOL_W-1:0]     m_texel_col,
    output logic [twcs_pkg::TEXCOL_W-1:0]     m_texel_row,
    output logic [1:0]                        m_face_out,
    output logic                              m_side_out,
    output logic                              m_last_row
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    localparam logic signed [twcs_pkg::POS_W-1:0] POS_MAX =
        {1'b0, {(twcs_pkg::POS_W - 1){1'b1}}};
    localparam logic signed [twcs_pkg::POS_W-1:0] POS_MIN =
        {1'b1, {(twcs_pkg::POS_W - 1){1'b0}}};

    logic [1:0]                            state_reg, state_next;
    logic                                  span_active_reg;
    logic [twcs_pkg::ROW_W-1:0]            row_now_reg;
    logic [twcs_pkg::ROW_W-1:0]            row_end_reg;
    logic [twcs_pkg::COL_W-1:0]            column_reg;
    logic [twcs_pkg::TEXCOL_W-1:0]         texcol_reg;
    logic [twcs_pkg::FACE_SIDE_W-1:0]      face_side_reg;
    logic signed [twcs_pkg::POS_W-1:0]     pos_reg;
    logic [twcs_pkg::STEP_W-1:0]           step_reg;
    logic signed [twcs_pkg::CENTER_W-1:0]  center_reg;
    logic signed [twcs_pkg::PROD_W-1:0]    prod_reg;
    logic                                  m_valid_reg;

    logic [twcs_pkg::TEX_W-1:0]            th;
    logic [twcs_pkg::TEX_W-1:0]            th_m1;
    logic                                  out_free;
    logic                                  pop_advance;
    logic                                  pop_load;
    logic                                  pop_clear;
    logic                                  div_start;
    logic                                  div_done;
    logic [twcs_pkg::DIVIDEND_W-1:0]       div_q;
    logic [twcs_pkg::TEXCOL_W-1:0]         row_tex;
    logic [twcs_pkg::PITCH_W+twcs_pkg::ROW_W:0] idx;
    logic signed [twcs_pkg::POS_W:0]       pos_sum;
    logic signed [twcs_pkg::POS_W-1:0]     pos_step;
    logic signed [twcs_pkg::POS_W-1:0]     prod_sat;
    logic                                  is_last;

    assign th    = twcs_pkg::tex_size(cfg.texture_height);
    assign th_m1 = th - twcs_pkg::TEX_W'(1);

    assign out_free    = !m_valid_reg || m_ready;
    assign q_pop       = (state_reg == ST_IDLE) && q_valid &&
                         (q_item.kind != twcs_pkg::CMD_ADVANCE || out_free);
    assign pop_advance = q_pop && (q_item.kind == twcs_pkg::CMD_ADVANCE);
    assign pop_load    = q_pop && (q_item.kind == twcs_pkg::CMD_LOAD);
    assign pop_clear   = q_pop && (q_item.kind != twcs_pkg::CMD_ADVANCE) &&
                         (q_item.kind != twcs_pkg::CMD_LOAD);
    assign div_start   = pop_load;

    twcs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({th, {twcs_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (q_item.wall_h),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        unique case (state_reg)
            ST_IDLE: state_next = pop_load ? ST_DIV : ST_IDLE;
            ST_DIV:  state_next = div_done ? ST_MUL : ST_DIV;
            ST_MUL:  state_next = ST_SAT;
            ST_SAT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // integer texel row, saturated to the texture
    always_comb begin
        if (pos_reg < 0) begin
            row_tex = '0;
        end else if (pos_reg[twcs_pkg::POS_W-2:twcs_pkg::FRAC_BITS] >
                     {{(twcs_pkg::POS_W - 1 - twcs_pkg::FRAC_BITS - twcs_pkg::TEX_W){1'b0}},
                      th_m1}) begin
            row_tex = th_m1[twcs_pkg::TEXCOL_W-1:0];
        end else begin
            row_tex = pos_reg[twcs_pkg::FRAC_BITS+twcs_pkg::TEXCOL_W-1:twcs_pkg::FRAC_BITS];
        end
    end

    assign idx = {{(twcs_pkg::ROW_W + 1){1'b0}}, cfg.row_pitch}
               * {{(twcs_pkg::PITCH_W + 1){1'b0}}, row_now_reg}
               + {{(twcs_pkg::PITCH_W + 1){1'b0}}, column_reg};
    assign is_last = (row_now_reg == row_end_reg);

    assign pos_sum  = {pos_reg[twcs_pkg::POS_W-1], pos_reg}
                    + $signed({{(twcs_pkg::POS_W + 1 - twcs_pkg::STEP_W){1'b0}}, step_reg});
    assign pos_step = (pos_sum[twcs_pkg::POS_W] != pos_sum[twcs_pkg::POS_W-1])
                    ? POS_MAX : pos_sum[twcs_pkg::POS_W-1:0];

    always_comb begin
        if (prod_reg > $signed({{(twcs_pkg::PROD_W - twcs_pkg::POS_W){1'b0}}, POS_MAX})) begin
            prod_sat = POS_MAX;
        end else if (prod_reg <
                     $signed({{(twcs_pkg::PROD_W - twcs_pkg::POS_W){1'b1}}, POS_MIN})) begin
            prod_sat = POS_MIN;
        end else begin
            prod_sat = prod_reg[twcs_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            span_active_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
            row_now_reg     <= '0;
            row_end_reg     <= '0;
            column_reg      <= '0;
            texcol_reg      <= '0;
            face_side_reg   <= '0;
            pos_reg         <= '0;
            step_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready && !(pop_advance && span_active_reg)) begin
                m_valid_reg <= 1'b0;
            end
            if (pop_clear) begin
                span_active_reg <= 1'b0;
            end
            if (pop_load) begin
                span_active_reg <= 1'b0;
                row_now_reg     <= q_item.row_top;
                row_end_reg     <= q_item.row_bot;
                column_reg      <= q_item.column;
                texcol_reg      <= q_item.texcol;
                face_side_reg   <= q_item.face_side;
            end
            if (state_reg == ST_DIV && div_done) begin
                step_reg <= twcs_pkg::STEP_W'(div_q);
            end
            if (state_reg == ST_SAT) begin
                pos_reg         <= prod_sat;
                span_active_reg <= 1'b1;
            end
            if (pop_advance && span_active_reg) begin
                m_valid_reg <= 1'b1;
                pos_reg     <= pos_step;
                if (is_last) begin
                    span_active_reg <= 1'b0;
                end else begin
                    row_now_reg <= row_now_reg + twcs_pkg::ROW_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_load) begin
            center_reg <= q_item.center_off;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= twcs_pkg::PROD_W'(center_reg) *
                        twcs_pkg::PROD_W'($signed({1'b0, step_reg}));
        end
        if (pop_advance && span_active_reg) begin
            m_pixel_index <= idx[twcs_pkg::PIXEL_W-1:0];
            m_texel_col   <= texcol_reg;
            m_texel_row   <= row_tex;
            m_face_out    <= face_side_reg[1:0];
            m_side_out    <= face_side_reg[2];
            m_last_row    <= is_last;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- design/textured_wall_column_span_top.sv -----
// textured_wall_column_span_top: top level of the textured wall column span stepper
// holds the configuration registers; depends on twcs_pkg, twcs_front, twcs_queue, twcs_back
//
// usage
//   s_ channel: valid/ready requests; mode 0 loads a column span, mode 1 advances one row
//   m_ channel: valid/ready results, one per advance on an active span
//   cfg port: cfg_wr_en writes cfg_data into register cfg_index at the clock edge
//     (0 screen height, 1 row pitch, 2 texture width, 3 texture height)
//   requests enter a two-entry queue; s_ready drops only when the queue is full
//   a load occupies the back end from the cycle it leaves the queue, through the
//     bit-serial step divider, then the multiply state and the saturation state
//   an advance result is registered when the back end takes the request from the queue;
//     advances sustain one result per cycle while m_ready is high and no load is pending
//   an advance with no active span and a load with an empty span give no result
//   when the receiver stalls the result register holds, the back end stops
//     taking advances and the queue fills before s_ready drops
//   synchronous active-low reset empties the queue, drops the span and restores
//     480 rows, pitch 640 and a 64 by 64 texture

module textured_wall_column_span_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [twcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [twcs_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic [twcs_pkg::COL_W-1:0]          s_column_x,
    input  logic signed [twcs_pkg::FIELD_W-1:0] s_span_top,
    input  logic signed [twcs_pkg::FIELD_W-1:0] s_span_bottom,
    input  logic signed [twcs_pkg::FIELD_W-1:0] s_wall_height,
    input  logic signed [twcs_pkg::FIELD_W-1:0] s_texture_column,
    input  logic [1:0]                          s_wall_face,
    input  logic                                s_shaded_side,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [twcs_pkg::PIXEL_W-1:0]        m_pixel_index,
    output logic [twcs_pkg::TEXCOL_W-1:0]       m_texel_col,
    output logic [twcs_pkg::TEXCOL_W-1:0]       m_texel_row,
    output logic [1:0]                          m_face_out,
    output logic                                m_side_out,
    output logic                                m_last_row
);

    twcs_pkg::cfg_t  cfg_reg;
    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    twcs_pkg::item_t push_item;
    twcs_pkg::item_t q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_height  <= twcs_pkg::SCREEN_HEIGHT_RST;
            cfg_reg.row_pitch      <= twcs_pkg::ROW_PITCH_RST;
            cfg_reg.texture_width  <= twcs_pkg::TEXTURE_WIDTH_RST;
            cfg_reg.texture_height <= twcs_pkg::TEXTURE_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                twcs_pkg::REG_SCREEN_HEIGHT:
                    cfg_reg.screen_height <= cfg_data[twcs_pkg::SCR_W-1:0];
                twcs_pkg::REG_ROW_PITCH:
                    cfg_reg.row_pitch <= cfg_data[twcs_pkg::PITCH_W-1:0];
                twcs_pkg::REG_TEXTURE_WIDTH:
                    cfg_reg.texture_width <= cfg_data[twcs_pkg::TEX_W-1:0];
                twcs_pkg::REG_TEXTURE_HEIGHT:
                    cfg_reg.texture_height <= cfg_data[twcs_pkg::TEX_W-1:0];
                default: ;
            endcase
        end
    end

    twcs_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_column_x       (s_column_x),
        .s_span_top       (s_span_top),
        .s_span_bottom    (s_span_bottom),
        .s_wall_height    (s_wall_height),
        .s_texture_column (s_texture_column),
        .s_wall_face      (s_wall_face),
        .s_shaded_side    (s_shaded_side),
        .cfg              (cfg_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (push_item)
    );

    twcs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    twcs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_index (m_pixel_index),
        .m_texel_col   (m_texel_col),
        .m_texel_row   (m_texel_row),
        .m_face_out    (m_face_out),
        .m_side_out    (m_side_out),
        .m_last_row    (m_last_row)
    );

endmodule
